>>> design/adsr_envelope_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// ADSR envelope generator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_GENERATOR_UNIT_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ADSR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("adsr assertion failed");

// Next-cycle implication.
`define ADSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("adsr assertion failed");

`endif

>>> design/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope generator package
// Types, codes, the rate period table and the period load arithmetic.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int unsigned RateW  = 17;
  localparam int unsigned LimitW = 15;

  localparam logic [7:0] CyclesPerTickRst = 8'd63;
  localparam logic [7:0] SrByteRst        = 8'hF0;
  localparam logic [4:0] ExpoLimitRst     = 5'd1;
  localparam logic [LimitW-1:0] RateLimitRst = 15'd9;
  localparam logic signed [RateW:0] DelayWrap = 18'sd32767;

  // Item commands.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Register selects.
  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_AD      = 2'd1;
  localparam logic [1:0] SEL_SR      = 2'd2;

  // Phase codes as seen on the result port.
  localparam logic [1:0] PHASE_CODE_ATTACK  = 2'd0;
  localparam logic [1:0] PHASE_CODE_DECAY   = 2'd1;
  localparam logic [1:0] PHASE_CODE_RELEASE = 2'd2;

  typedef enum logic [2:0] {
    PH_ATTACK  = 3'b001,
    PH_DECAY   = 3'b010,
    PH_RELEASE = 3'b100
  } phase_e;

  typedef struct packed {
    logic       command;
    logic [1:0] reg_select;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0] level;
    logic [1:0] phase;
    logic       frozen;
  } result_t;

  typedef struct packed {
    logic signed [RateW-1:0] rate_count;
    logic [LimitW-1:0]       rate_limit;
  } status_t;

  function automatic logic [LimitW-1:0] period_lookup(input logic [3:0] nibble);
    logic [LimitW-1:0] p;
    unique case (nibble)
      4'd0:  p = 15'd9;
      4'd1:  p = 15'd32;
      4'd2:  p = 15'd63;
      4'd3:  p = 15'd95;
      4'd4:  p = 15'd149;
      4'd5:  p = 15'd220;
      4'd6:  p = 15'd267;
      4'd7:  p = 15'd313;
      4'd8:  p = 15'd392;
      4'd9:  p = 15'd977;
      4'd10: p = 15'd1954;
      4'd11: p = 15'd3126;
      4'd12: p = 15'd3907;
      4'd13: p = 15'd11720;
      4'd14: p = 15'd19532;
      4'd15: p = 15'd31251;
    endcase
    return p;
  endfunction

  // Counter adjustment on a period load: the counter may sit a whole wrap
  // away from the new period, so it is pulled by one wrap either way.
  function automatic logic signed [RateW-1:0] load_count(
    input logic signed [RateW-1:0] cnt,
    input logic [LimitW-1:0]       lim
  );
    logic signed [RateW:0] c;
    logic signed [RateW:0] l;
    c = {cnt[RateW-1], cnt};
    l = $signed({3'b000, lim});
    if ((l - c) > DelayWrap) begin
      c = c + DelayWrap;
    end
    if (l <= c) begin
      c = c - DelayWrap;
    end
    return c[RateW-1:0];
  endfunction

  function automatic logic [1:0] phase_code(input phase_e ph);
    logic [1:0] code;
    unique case (ph)
      PH_ATTACK: code = PHASE_CODE_ATTACK;
      PH_DECAY:  code = PHASE_CODE_DECAY;
      default:   code = PHASE_CODE_RELEASE;
    endcase
    return code;
  endfunction

endpackage

>>> design/adsr_core.sv
// ----------------------------------------------------------------------------
// ADSR envelope core
// Envelope state registers and the single-pass next-state logic per item.
// ----------------------------------------------------------------------------
module adsr_core import adsr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_fire_i,
  input  item_t   item_i,
  input  logic    cfg_we_i,
  input  logic [7:0] cfg_data_i,
  output result_t result_o,
  output status_t status_o
);

  logic [7:0]              cpt_q;
  logic signed [RateW-1:0] cnt_q, cnt_d;
  logic [LimitW-1:0]       lim_q, lim_d;
  logic [7:0]              expo_q, expo_d;
  logic [4:0]              expo_lim_q, expo_lim_d;
  logic [7:0]              lvl_q, lvl_d;
  phase_e                  ph_q, ph_d;
  logic                    hold_q, hold_d;
  logic                    gate_q, gate_d;
  logic [7:0]              ad_q, ad_d;
  logic [7:0]              sr_q, sr_d;

  logic signed [RateW:0]   sum;
  logic                    step;
  logic [7:0]              sustain;

  always_comb begin
    cnt_d      = cnt_q;
    lim_d      = lim_q;
    expo_d     = expo_q;
    expo_lim_d = expo_lim_q;
    lvl_d      = lvl_q;
    ph_d       = ph_q;
    hold_d     = hold_q;
    gate_d     = gate_q;
    ad_d       = ad_q;
    sr_d       = sr_q;
    sum        = {cnt_q[RateW-1], cnt_q} + $signed({10'd0, cpt_q});
    step       = 1'b0;
    sustain    = {sr_q[7:4], sr_q[7:4]};

    if (item_i.command == CMD_TICK) begin
      if (sum < $signed({3'b000, lim_q})) begin
        cnt_d = sum[RateW-1:0];
      end else begin
        cnt_d = '0;
        step  = 1'b1;
        // The prescaler is bypassed in attack.
        if (ph_q != PH_ATTACK) begin
          expo_d = expo_q + 8'd1;
          if (expo_d != {3'b000, expo_lim_q}) begin
            step = 1'b0;
          end
        end
      end
      if (step) begin
        expo_d = '0;
        if (!hold_q) begin
          unique case (ph_q)
            PH_ATTACK: begin
              lvl_d = lvl_q + 8'd1;
              if (lvl_d == 8'hff) begin
                ph_d  = PH_DECAY;
                lim_d = period_lookup(ad_q[3:0]);
                cnt_d = load_count(cnt_d, lim_d);
              end
            end
            PH_DECAY: begin
              if (lvl_q != sustain) begin
                lvl_d = lvl_q - 8'd1;
              end
            end
            default: begin
              lvl_d = lvl_q - 8'd1;
            end
          endcase
          // Exponential breakpoints; reaching zero freezes the level.
          unique case (lvl_d)
            8'hff:   expo_lim_d = 5'd1;
            8'h5d:   expo_lim_d = 5'd2;
            8'h36:   expo_lim_d = 5'd4;
            8'h1a:   expo_lim_d = 5'd8;
            8'h0e:   expo_lim_d = 5'd16;
            8'h06:   expo_lim_d = 5'd30;
            8'h00: begin
              expo_lim_d = 5'd1;
              hold_d     = 1'b1;
            end
            default: expo_lim_d = expo_lim_q;
          endcase
        end
      end
    end else begin
      unique case (item_i.reg_select)
        SEL_CONTROL: gate_d = item_i.write_data[0];
        SEL_AD:      ad_d   = item_i.write_data;
        SEL_SR:      sr_d   = item_i.write_data;
        default:     gate_d = gate_q;
      endcase
      // Gate edges first, then the handler of the phase that results.
      if (!gate_q && gate_d) begin
        ph_d   = PH_ATTACK;
        lim_d  = period_lookup(ad_d[7:4]);
        cnt_d  = load_count(cnt_d, lim_d);
        hold_d = 1'b0;
      end else if (gate_q && !gate_d) begin
        ph_d  = PH_RELEASE;
        lim_d = period_lookup(sr_d[3:0]);
        cnt_d = load_count(cnt_d, lim_d);
      end
      unique case (ph_d)
        PH_ATTACK: lim_d = period_lookup(ad_d[7:4]);
        PH_DECAY:  lim_d = period_lookup(ad_d[3:0]);
        default:   lim_d = period_lookup(sr_d[3:0]);
      endcase
      cnt_d = load_count(cnt_d, lim_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpt_q      <= CyclesPerTickRst;
      cnt_q      <= '0;
      lim_q      <= RateLimitRst;
      expo_q     <= '0;
      expo_lim_q <= ExpoLimitRst;
      lvl_q      <= '0;
      ph_q       <= PH_RELEASE;
      hold_q     <= 1'b1;
      gate_q     <= 1'b0;
      ad_q       <= '0;
      sr_q       <= SrByteRst;
    end else begin
      if (cfg_we_i) begin
        cpt_q <= cfg_data_i;
      end
      if (item_fire_i) begin
        cnt_q      <= cnt_d;
        lim_q      <= lim_d;
        expo_q     <= expo_d;
        expo_lim_q <= expo_lim_d;
        lvl_q      <= lvl_d;
        ph_q       <= ph_d;
        hold_q     <= hold_d;
        gate_q     <= gate_d;
        ad_q       <= ad_d;
        sr_q       <= sr_d;
      end
    end
  end

  assign result_o.level  = lvl_d;
  assign result_o.phase  = phase_code(ph_d);
  assign result_o.frozen = hold_d;

  assign status_o.rate_count = cnt_q;
  assign status_o.rate_limit = lim_q;

endmodule

>>> design/adsr_envelope_generator_unit.sv
// ----------------------------------------------------------------------------
// ADSR envelope generator unit
// One voice's envelope generator with exponential decay, one result per item.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Beat carries
//   in       sink       in_valid_i/in_stall_o  command, reg_select, write_data
//   out      source     out_valid_o/out_stall_i level, phase, frozen flag
//   cfg      sink       cfg_valid_i/cfg_ready_o cycles per tick
//
// One item is accepted per cycle while in_stall_o is low. The input register
// takes the beat, the core works on it combinationally and the result
// register is loaded from the core output when the result is not stalled.
// Reset puts the envelope in release, frozen at zero; no clearing pass.
// A stalled result holds the input register, which then raises in_stall_o.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_unit import adsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [1:0] reg_select_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] envelope_level_o,
  output logic [1:0] envelope_phase_o,
  output logic       frozen_at_zero_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t res_q;
  result_t core_res;
  status_t core_stat;
  logic    out_hold;
  logic    advance;
  logic    rate_in_range;

  assign out_hold   = out_valid_q && out_stall_i;
  assign advance    = in_valid_q && !out_hold;
  assign in_stall_o = in_valid_q && out_hold;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.command    <= command_i;
      item_q.reg_select <= reg_select_i;
      item_q.write_data <= write_data_i;
    end
  end

  adsr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_fire_i (advance),
    .item_i      (item_q),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .result_o    (core_res),
    .status_o    (core_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_hold) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign envelope_level_o = res_q.level;
  assign envelope_phase_o = res_q.phase;
  assign frozen_at_zero_o = res_q.frozen;

  assign rate_in_range = $signed(core_stat.rate_count) < $signed({2'b00, core_stat.rate_limit});

`include "adsr_envelope_generator_unit_assert.svh"

  `ADSR_ASSERT_SAME(a_frozen_level_zero, out_valid_o && frozen_at_zero_o, envelope_level_o == 8'h00)
  `ADSR_ASSERT_SAME(a_rate_below_limit, 1'b1, rate_in_range)
  `ADSR_ASSERT_NEXT(a_accept_to_stage, in_valid_i && !in_stall_o, in_valid_q)
  `ADSR_ASSERT_NEXT(a_stage_to_result, in_valid_q && !(out_valid_o && out_stall_i), out_valid_o)

endmodule
